### src/dgfpw_pkg.sv
// Shared constants, bus instruction codes and the item descriptor for the
// dual-controller graphic LCD frame page writer. No dependencies.
package dgfpw_pkg;

  localparam int unsigned CONTROLLER_SIZE = 64;
  localparam int unsigned DISPLAY_WIDTH   = 128;

  localparam int unsigned ROW_BYTES   = DISPLAY_WIDTH / 8;
  localparam int unsigned HALF_BYTES  = CONTROLLER_SIZE / 8;
  localparam int unsigned STORED_ROWS = 7;
  localparam int unsigned FRAME_BYTES = ROW_BYTES * CONTROLLER_SIZE;

  localparam int unsigned STORE_W     = STORED_ROWS * 8;
  localparam int unsigned STORE_DEPTH = ROW_BYTES;
  localparam int unsigned STORE_AW    = $clog2(ROW_BYTES);
  localparam int unsigned HALF_AW     = $clog2(HALF_BYTES);
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0] CMD_PAGE       = 8'hB8;
  localparam logic [7:0] CMD_COL        = 8'h40;
  localparam logic [7:0] CMD_START_LINE = 8'hC0;
  localparam logic [7:0] CMD_ON         = 8'h3F;
  localparam logic [7:0] CMD_OFF        = 8'h3E;

  // Everything the result sequencer needs to know about one input byte.
  typedef struct packed {
    logic [7:0] pix;
    logic       ctl;
    logic [2:0] page;
    logic       start;
    logic       eighth;
    logic       first;
    logic       frame_end;
  } item_t;

endpackage

### src/dgfpw_ram.sv
// Generic single-write, single-read synchronous RAM with a bit write mask
// and a registered read port. No dependencies.
module dgfpw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wmask_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= (mem_q[waddr_i] & ~wmask_i) | (wdata_i & wmask_i);
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/dgfpw_seq.sv
// Result sequencer: steps through the bus transactions of one byte and
// holds them in the output register. Depends on dgfpw_pkg.
module dgfpw_seq import dgfpw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  item_t              item_i,
  input  logic [STORE_W-1:0] rows_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               controller_o,
  output logic               is_data_o,
  output logic [7:0]         bus_byte_o,
  output logic               last_o
);

  typedef enum logic [8:0] {
    PH_IDLE = 9'b000000001,
    PH_OFF0 = 9'b000000010,
    PH_OFF1 = 9'b000000100,
    PH_COL  = 9'b000001000,
    PH_LINE = 9'b000010000,
    PH_PAGE = 9'b000100000,
    PH_DATA = 9'b001000000,
    PH_ON0  = 9'b010000000,
    PH_ON1  = 9'b100000000
  } phase_e;

  phase_e     phase_q, phase_d, phase_nx, phase_first;
  logic [2:0] col_q, col_d;
  item_t      cur_q, cur_d;

  logic       out_valid_q, out_valid_d;
  logic       ctl_q, ctl_d;
  logic       is_data_q, is_data_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;

  logic       adv;
  logic       final_step;
  logic [7:0] seg;

  // First transaction of a freshly accepted byte.
  always_comb begin
    if (item_i.start) begin
      phase_first = PH_OFF0;
    end else if (item_i.eighth) begin
      if (item_i.first) begin
        phase_first = (item_i.page == 3'd0) ? PH_COL : PH_PAGE;
      end else begin
        phase_first = PH_DATA;
      end
    end else begin
      phase_first = PH_IDLE;
    end
  end

  // A frame start always lands on a stored row, so display off ends the byte.
  always_comb begin
    case (phase_q)
      PH_OFF0: phase_nx = PH_OFF1;
      PH_OFF1: phase_nx = PH_IDLE;
      PH_COL:  phase_nx = PH_LINE;
      PH_LINE: phase_nx = PH_PAGE;
      PH_PAGE: phase_nx = PH_DATA;
      PH_DATA: begin
        if (col_q == 3'd7) begin
          phase_nx = cur_q.frame_end ? PH_ON0 : PH_IDLE;
        end else begin
          phase_nx = PH_DATA;
        end
      end
      PH_ON0:  phase_nx = PH_ON1;
      PH_ON1:  phase_nx = PH_IDLE;
      default: phase_nx = PH_IDLE;
    endcase
  end

  assign adv        = (phase_q != PH_IDLE) && (!out_valid_q || out_ready_i);
  assign final_step = (phase_nx == PH_IDLE);
  assign ready_o    = (phase_q == PH_IDLE) || (adv && final_step);

  // Column col_q of the eight: bit k is row k of the page, the new byte on top.
  always_comb begin
    logic [7:0] lane;
    logic [2:0] sh;
    sh  = 3'd7 - col_q;
    seg = 8'h00;
    for (int k = 0; k < int'(STORED_ROWS); k++) begin
      lane   = rows_i[8*k +: 8];
      seg[k] = lane[sh];
    end
    seg[7] = cur_q.pix[sh];
  end

  always_comb begin
    phase_d     = phase_q;
    col_d       = col_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    ctl_d       = ctl_q;
    is_data_d   = is_data_q;
    byte_d      = byte_q;
    last_d      = last_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (adv) begin
      out_valid_d = 1'b1;
      last_d      = final_step;
      is_data_d   = 1'b0;
      ctl_d       = cur_q.ctl;
      case (phase_q)
        PH_OFF0: begin
          ctl_d  = 1'b0;
          byte_d = CMD_OFF;
        end
        PH_OFF1: begin
          ctl_d  = 1'b1;
          byte_d = CMD_OFF;
        end
        PH_COL:  byte_d = CMD_COL;
        PH_LINE: byte_d = CMD_START_LINE;
        PH_PAGE: byte_d = CMD_PAGE | {5'd0, cur_q.page};
        PH_DATA: begin
          is_data_d = 1'b1;
          byte_d    = seg;
        end
        PH_ON0: begin
          ctl_d  = 1'b0;
          byte_d = CMD_ON;
        end
        PH_ON1: begin
          ctl_d  = 1'b1;
          byte_d = CMD_ON;
        end
        default: byte_d = byte_q;
      endcase
      phase_d = phase_nx;
      if (phase_q == PH_DATA) begin
        col_d = col_q + 3'd1;
      end
    end

    if (load_i) begin
      phase_d = phase_first;
      col_d   = 3'd0;
      cur_d   = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      col_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    ctl_q     <= ctl_d;
    is_data_q <= is_data_d;
    byte_q    <= byte_d;
    last_q    <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign controller_o = ctl_q;
  assign is_data_o    = is_data_q;
  assign bus_byte_o   = byte_q;
  assign last_o       = last_q;

endmodule

### src/dual_glcd_frame_page_writer.sv
// Top level of the dual-controller 128x64 graphic LCD frame page writer.
// Depends on dgfpw_pkg, dgfpw_ram and dgfpw_seq.
//
// Takes a row-major 1bpp frame one byte per transfer and turns it into bus
// transactions for two 64-column controllers. Bytes of the first seven rows
// of a page go into a 16 x 56-bit row store (one word per byte column, one
// byte lane per row). They are taken one per cycle while the sequencer is
// idle, with no result apart from the display-off pair on a frame start. The
// byte of a page's eighth row reads its word back through the registered read
// port and the sequencer emits up to eleven transactions, one per cycle while
// the bus side takes them, from a single output register, once it has loaded
// the byte. The next byte is taken in the cycle the last transaction of the
// current one is produced. No reset sweep is needed: every row-store word is
// written before it is read within a frame.
module dual_glcd_frame_page_writer import dgfpw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] pixel_byte_i,
  input  logic       frame_start_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       controller_o,
  output logic       is_data_o,
  output logic [7:0] bus_byte_o,
  output logic       last_o
);

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0]    pos_q, pos_d, pos;
  logic                accept;
  logic [STORE_AW-1:0] byte_idx;
  logic [2:0]          row_in_page;
  item_t               item;
  logic [STORE_W-1:0]  wmask;
  logic [STORE_W-1:0]  rows;
  logic                seq_ready;

  assign pos         = frame_start_i ? '0 : pos_q;
  assign byte_idx    = pos[STORE_AW-1:0];
  assign row_in_page = pos[STORE_AW +: 3];

  assign item.pix       = pixel_byte_i;
  assign item.ctl       = ~pos[STORE_AW-1];
  assign item.page      = pos[STORE_AW+3 +: 3];
  assign item.start     = frame_start_i;
  assign item.eighth    = (row_in_page == 3'd7);
  assign item.first     = (pos[HALF_AW-1:0] == '0);
  assign item.frame_end = (pos == POS_LAST);

  assign in_ready_o = seq_ready;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_d      = accept ? pos + POS_W'(1) : pos_q;

  always_comb begin
    for (int k = 0; k < int'(STORED_ROWS); k++) begin
      wmask[8*k +: 8] = {8{row_in_page == 3'(k)}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  dgfpw_ram #(
    .Width (STORE_W),
    .Depth (STORE_DEPTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (accept && !item.eighth),
    .waddr_i (byte_idx),
    .wmask_i (wmask),
    .wdata_i ({STORED_ROWS{pixel_byte_i}}),
    .re_i    (accept && item.eighth),
    .raddr_i (byte_idx),
    .rdata_o (rows)
  );

  dgfpw_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .item_i       (item),
    .rows_i       (rows),
    .ready_o      (seq_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .controller_o (controller_o),
    .is_data_o    (is_data_o),
    .bus_byte_o   (bus_byte_o),
    .last_o       (last_o)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for dual_glcd_frame_page_writer: frames of pixel bytes go in and
// the controller bus transfers that come out are compared with a built-in prediction.
// Depends on dgfpw_pkg and the RTL of the block.
module testbench;
  import dgfpw_pkg::*;

  typedef struct packed {
    logic       ctl;
    logic       is_data;
    logic [7:0] data;
    logic       last;
  } bus_xfer_t;

  typedef bus_xfer_t xfer_q_t [$];

  typedef struct {
    logic [7:0] pix;
    bit         start;
    int         reps;
    bit         off_pair;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] pixel_byte_i = 8'h00;
  logic       frame_start_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       controller_o;
  logic       is_data_o;
  logic [7:0] bus_byte_o;
  logic       last_o;

  // Prediction state: rows 0..6 of the current page and the position in the frame.
  logic [7:0]       page_rows [STORED_ROWS][ROW_BYTES];
  logic [POS_W-1:0] frame_pos = '0;

  xfer_q_t   pending_xfers;
  bus_xfer_t head_xfer;
  int        fail_count = 0;
  int        tx_calm = 0;
  int        rx_calm = 0;

  bus_xfer_t off_pair [2] = '{'{1'b0, 1'b0, CMD_OFF, 1'b0}, '{1'b1, 1'b0, CMD_OFF, 1'b1}};

  // Rows flagged off_pair are frame starts whose transfers are written out here; the rest
  // are checked against the prediction.
  stim_row_t directed_rows [7] = '{
    '{8'h00, 1'b1,   1, 1'b1},
    '{8'hC3, 1'b0,  20, 1'b0},
    '{8'h7E, 1'b1,   1, 1'b1},
    '{8'hFF, 1'b0, 111, 1'b0},
    '{8'h80, 1'b0,   1, 1'b0},
    '{8'h01, 1'b0,   1, 1'b0},
    '{8'hFF, 1'b0,   6, 1'b0}
  };

  dual_glcd_frame_page_writer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_byte_i (pixel_byte_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .controller_o (controller_o),
    .is_data_o    (is_data_o),
    .bus_byte_o   (bus_byte_o),
    .last_o       (last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic bus_xfer_t xfer(logic ctl, logic is_data, logic [7:0] data);
    xfer = '{ctl, is_data, data, 1'b0};
  endfunction

  // Bus transfers caused by one pixel byte; updates the row store and the position.
  function automatic xfer_q_t predict_bus(logic [7:0] pix, logic start);
    xfer_q_t          seq;
    logic [POS_W-1:0] p;
    logic [3:0]       col_b;
    logic [2:0]       row_i;
    logic [2:0]       page;
    logic             side;
    logic [7:0]       column;
    if (start) frame_pos = '0;
    p     = frame_pos;
    col_b = p[3:0];
    row_i = p[6:4];
    page  = p[9:7];
    side  = ~col_b[3];
    if (start) begin
      seq.push_back(xfer(1'b0, 1'b0, CMD_OFF));
      seq.push_back(xfer(1'b1, 1'b0, CMD_OFF));
    end
    if (row_i != 3'd7) begin
      page_rows[row_i][col_b] = pix;
    end else begin
      if (col_b[2:0] == 3'd0) begin
        if (page == 3'd0) begin
          seq.push_back(xfer(side, 1'b0, CMD_COL));
          seq.push_back(xfer(side, 1'b0, CMD_START_LINE));
          seq.push_back(xfer(side, 1'b0, CMD_PAGE));
        end else begin
          seq.push_back(xfer(side, 1'b0, CMD_PAGE + {5'd0, page}));
        end
      end
      // Leftmost pixel first; bit k of a column byte is row k of the page.
      for (int c = 0; c < 8; c++) begin
        for (int k = 0; k < 7; k++) column[k] = page_rows[k][col_b][7 - c];
        column[7] = pix[7 - c];
        seq.push_back(xfer(side, 1'b1, column));
      end
      if (&p) begin
        seq.push_back(xfer(1'b0, 1'b0, CMD_ON));
        seq.push_back(xfer(1'b1, 1'b0, CMD_ON));
      end
    end
    if (seq.size() > 0) seq[seq.size() - 1].last = 1'b1;
    frame_pos = p + 1'b1;
    return seq;
  endfunction

  // Mostly uniform gaps, with occasional stretches of back-to-back transfers.
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm_left = $urandom_range(20, 120);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  task automatic send_byte(logic [7:0] pix, logic start, bit typed_off);
    int      gap;
    xfer_q_t seq;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_byte_i  <= pix;
    frame_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    seq = predict_bus(pix, start);
    if (typed_off) begin
      pending_xfers.push_back(off_pair[0]);
      pending_xfers.push_back(off_pair[1]);
    end else begin
      foreach (seq[i]) pending_xfers.push_back(seq[i]);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_xfers.size() == 0) begin
        $error("unexpected bus transfer: controller %0d is_data %0d byte %h last %0d",
               controller_o, is_data_o, bus_byte_o, last_o);
        fail_count++;
      end else begin
        head_xfer = pending_xfers.pop_front();
        if (controller_o !== head_xfer.ctl) begin
          $error("controller: expected %0d, got %0d", head_xfer.ctl, controller_o);
          fail_count++;
        end
        if (is_data_o !== head_xfer.is_data) begin
          $error("is_data: expected %0d, got %0d", head_xfer.is_data, is_data_o);
          fail_count++;
        end
        if (bus_byte_o !== head_xfer.data) begin
          $error("bus_byte: expected %h, got %h", head_xfer.data, bus_byte_o);
          fail_count++;
        end
        if (last_o !== head_xfer.last) begin
          $error("last: expected %0d, got %0d", head_xfer.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Bus side. Early on it holds off for a long stretch so that the block backs up
  // into its input while eighth-row bytes are still being offered.
  initial begin : bus_receiver
    int gap;
    int taken;
    taken = 0;
    wait (rst_ni);
    forever begin
      gap = draw_gap(rx_calm);
      if (taken == 15) gap = 200;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin : pixel_sender
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].reps; i++) begin
        send_byte(directed_rows[r].pix, directed_rows[r].start && (i == 0),
                  directed_rows[r].off_pair);
      end
    end
    // Random pixels from the second half of page 0's eighth row on, which needs its own
    // page setup for the right-hand controller, then into the stored rows of page 1.
    for (int i = 0; i < 64; i++) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
    in_valid_i <= 1'b0;
    while (pending_xfers.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0 && pending_xfers.size() == 0) begin
      $display("** dual_glcd_frame_page_writer: PASSED **");
    end else begin
      $display("** dual_glcd_frame_page_writer: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("** dual_glcd_frame_page_writer: FAILED **");
    $finish;
  end

endmodule
